>>> hdl/hpa_pkg.sv
// Package: widths, pipeline geometry and shared types of the triangle perimeter/area block.
package hpa_pkg;

    localparam int CW       = 24;             // coordinate width, 8 fractional bits
    localparam int DW       = CW + 1;         // magnitude of a coordinate difference
    localparam int NW       = 2 * DW;         // squared distance
    localparam int SW       = DW;             // side length
    localparam int PSW      = SW + 2;         // sum of three sides
    localparam int QW       = 2 * PSW;        // root of the Heron product
    localparam int RW       = 4 * PSW;        // Heron product
    localparam int REMW     = QW + 2;         // square-root remainder
    localparam int SSTEPS   = SW;             // cells per side root
    localparam int ASTEPS   = QW;             // cells for the area root
    localparam int FRONT    = 3;              // diff, square, sum stages
    localparam int HERON    = 4;              // sums, two products, partials, wide add
    localparam int LAT      = FRONT + SSTEPS + HERON + ASTEPS;

    localparam int PERIM_W  = 27;
    localparam int AREA_W   = 48;
    localparam int PXW      = (PSW > PERIM_W) ? PSW : PERIM_W;
    localparam int AXW      = ((QW - 2) > AREA_W) ? (QW - 2) : AREA_W;

    localparam logic [PERIM_W-1:0] PERIM_MAX = '1;
    localparam logic [AREA_W-1:0]  AREA_MAX  = '1;

    // one digit-recurrence square-root step: radicand still to consume, remainder, root so far
    typedef struct packed {
        logic [RW-1:0]   rad;
        logic [REMW-1:0] rem;
        logic [QW-1:0]   root;
    } t_sq;

    typedef struct packed {
        logic [PERIM_W-1:0] perimeter;
        logic [AREA_W-1:0]  area;
        logic               degenerate;
    } t_res;

endpackage

>>> hdl/hpa_if.sv
// Interfaces: triangle input channel and result output channel.
interface hpa_tri_if;
    logic                          valid;
    logic                          ready;
    logic signed [hpa_pkg::CW-1:0] ax;
    logic signed [hpa_pkg::CW-1:0] ay;
    logic signed [hpa_pkg::CW-1:0] bx;
    logic signed [hpa_pkg::CW-1:0] by;
    logic signed [hpa_pkg::CW-1:0] cx;
    logic signed [hpa_pkg::CW-1:0] cy;

    modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
    modport sink   (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

interface hpa_res_if;
    logic                           valid;
    logic                           ready;
    logic [hpa_pkg::PERIM_W-1:0]    perimeter;
    logic [hpa_pkg::AREA_W-1:0]     area;
    logic                           degenerate;

    modport source (output valid, perimeter, area, degenerate, input ready);
    modport sink   (input valid, perimeter, area, degenerate, output ready);
endinterface

>>> hdl/hpa_sqrt_cell.sv
// One square-root cell: consume two radicand bits, yield one root bit.
module hpa_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  hpa_pkg::t_sq  i_d,
    output hpa_pkg::t_sq  o_d
);

    logic [hpa_pkg::REMW-1:0] rem_sh;
    logic [hpa_pkg::REMW-1:0] trial;
    hpa_pkg::t_sq             n_d;
    hpa_pkg::t_sq             r_d;

    always_comb begin
        rem_sh   = {i_d.rem[hpa_pkg::QW-1:0], i_d.rad[hpa_pkg::RW-1 -: 2]};
        trial    = {i_d.root, 2'b01};
        n_d.rad  = {i_d.rad[hpa_pkg::RW-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_d.rem  = rem_sh - trial;
            n_d.root = {i_d.root[hpa_pkg::QW-2:0], 1'b1};
        end else begin
            n_d.rem  = rem_sh;
            n_d.root = {i_d.root[hpa_pkg::QW-2:0], 1'b0};
        end
    end

    // advance with the pipeline, hold on stall
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

>>> hdl/hpa_side.sv
// Side front end: squared distance between two vertices over three stages.
module hpa_side (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [hpa_pkg::CW-1:0] i_x1,
    input  logic signed [hpa_pkg::CW-1:0] i_y1,
    input  logic signed [hpa_pkg::CW-1:0] i_x2,
    input  logic signed [hpa_pkg::CW-1:0] i_y2,
    output logic [hpa_pkg::NW-1:0]        o_n
);

    logic signed [hpa_pkg::CW:0] dx;
    logic signed [hpa_pkg::CW:0] dy;
    logic [hpa_pkg::DW-1:0]      n_mx;
    logic [hpa_pkg::DW-1:0]      n_my;
    logic [hpa_pkg::DW-1:0]      r_mx;
    logic [hpa_pkg::DW-1:0]      r_my;
    logic [hpa_pkg::NW-1:0]      r_sx;
    logic [hpa_pkg::NW-1:0]      r_sy;
    logic [hpa_pkg::NW-1:0]      r_n;

    always_comb begin
        dx   = (hpa_pkg::CW+1)'(i_x1) - (hpa_pkg::CW+1)'(i_x2);
        dy   = (hpa_pkg::CW+1)'(i_y1) - (hpa_pkg::CW+1)'(i_y2);
        n_mx = dx[hpa_pkg::CW] ? hpa_pkg::DW'(-dx) : hpa_pkg::DW'(dx);
        n_my = dy[hpa_pkg::CW] ? hpa_pkg::DW'(-dy) : hpa_pkg::DW'(dy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx <= n_mx;
            r_my <= n_my;
            r_sx <= hpa_pkg::NW'(r_mx) * hpa_pkg::NW'(r_mx);
            r_sy <= hpa_pkg::NW'(r_my) * hpa_pkg::NW'(r_my);
            r_n  <= r_sx + r_sy;
        end
    end

    assign o_n = r_n;

endmodule

>>> hdl/triangle_perimeter_area.sv
// Top level: triangle perimeter and Heron area, pipelined through rows of square-root cells.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------------
//  i_tri    | in  | valid / ready       | ax ay bx by cx cy, signed, 8 fraction bits
//  o_res    | out | valid / ready       | perimeter, area, degenerate
//
//  One triangle enters per cycle while i_tri.ready is high; each result passes, at the default
//  coordinate width, through 3 front stages, 25 side-root cells, 4 Heron stages, 54 area-root
//  cells and 1 output register. The two rows of root cells set the latency.
//  Reset (i_rst_n low at a clock edge) empties the pipeline and the output registers.
//  A stalled output fills one skid register; only then does the pipeline hold and
//  i_tri.ready drop.
module triangle_perimeter_area (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpa_tri_if.sink    i_tri,
    hpa_res_if.source  o_res
);

    localparam int SBL   = hpa_pkg::HERON + hpa_pkg::ASTEPS;  // sideband length

    // pipeline advance: stop only when the skid register is holding a transaction
    logic en;
    logic take;
    logic accept;

    logic r_ov;
    logic r_skv;
    hpa_pkg::t_res r_o;
    hpa_pkg::t_res r_sk;
    hpa_pkg::t_res fin;

    logic [hpa_pkg::LAT-1:0] r_v;

    assign en     = !r_skv;
    assign accept = i_tri.valid && en;
    assign take   = r_ov && o_res.ready;
    assign i_tri.ready = en;

    // valid shift line, one bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[hpa_pkg::LAT-2:0], accept};
        end
    end

    // squared side lengths: AB, BC, CA
    logic [hpa_pkg::NW-1:0] sq_n [0:2];

    hpa_side u_side_ab (
        .i_clk (i_clk), .i_en (en),
        .i_x1  (i_tri.ax), .i_y1 (i_tri.ay), .i_x2 (i_tri.bx), .i_y2 (i_tri.by),
        .o_n   (sq_n[0])
    );
    hpa_side u_side_bc (
        .i_clk (i_clk), .i_en (en),
        .i_x1  (i_tri.bx), .i_y1 (i_tri.by), .i_x2 (i_tri.cx), .i_y2 (i_tri.cy),
        .o_n   (sq_n[1])
    );
    hpa_side u_side_ca (
        .i_clk (i_clk), .i_en (en),
        .i_x1  (i_tri.cx), .i_y1 (i_tri.cy), .i_x2 (i_tri.ax), .i_y2 (i_tri.ay),
        .o_n   (sq_n[2])
    );

    // side roots: radicand left-aligned so each cell takes the top two bits
    hpa_pkg::t_sq side_d [0:2][0:hpa_pkg::SSTEPS];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign side_d[l][0].rad  = {sq_n[l], {(hpa_pkg::RW - hpa_pkg::NW){1'b0}}};
        assign side_d[l][0].rem  = '0;
        assign side_d[l][0].root = '0;
        for (genvar k = 0; k < hpa_pkg::SSTEPS; k++) begin : g_cell
            hpa_sqrt_cell u_cell (
                .i_clk (i_clk), .i_en (en),
                .i_d   (side_d[l][k]), .o_d (side_d[l][k+1])
            );
        end
    end

    // Heron stage 1: s and the three differences, flag zero and negative factors
    logic [hpa_pkg::SW-1:0]      sa;
    logic [hpa_pkg::SW-1:0]      sb;
    logic [hpa_pkg::SW-1:0]      sc;
    logic [hpa_pkg::PSW-1:0]     s;
    logic signed [hpa_pkg::PSW:0] fx;
    logic signed [hpa_pkg::PSW:0] fy;
    logic signed [hpa_pkg::PSW:0] fz;
    logic                        any_zero;
    logic                        any_neg;
    logic                        ok;
    logic [hpa_pkg::PXW-1:0]     pe;
    logic [hpa_pkg::PERIM_W-1:0] n_pm;

    always_comb begin
        sa = side_d[0][hpa_pkg::SSTEPS].root[hpa_pkg::SW-1:0];
        sb = side_d[1][hpa_pkg::SSTEPS].root[hpa_pkg::SW-1:0];
        sc = side_d[2][hpa_pkg::SSTEPS].root[hpa_pkg::SW-1:0];
        s  = hpa_pkg::PSW'(sa) + hpa_pkg::PSW'(sb) + hpa_pkg::PSW'(sc);
        fx = (hpa_pkg::PSW+1)'(sb) + (hpa_pkg::PSW+1)'(sc) - (hpa_pkg::PSW+1)'(sa);
        fy = (hpa_pkg::PSW+1)'(sa) + (hpa_pkg::PSW+1)'(sc) - (hpa_pkg::PSW+1)'(sb);
        fz = (hpa_pkg::PSW+1)'(sa) + (hpa_pkg::PSW+1)'(sb) - (hpa_pkg::PSW+1)'(sc);
        any_zero = (s == '0) || (fx == '0) || (fy == '0) || (fz == '0);
        any_neg  = fx[hpa_pkg::PSW] || fy[hpa_pkg::PSW] || fz[hpa_pkg::PSW];
        ok       = !any_zero && !any_neg;
        pe       = hpa_pkg::PXW'(s);
        n_pm     = (pe > hpa_pkg::PXW'(hpa_pkg::PERIM_MAX)) ? hpa_pkg::PERIM_MAX
                                                           : pe[hpa_pkg::PERIM_W-1:0];
    end

    // Heron operands, zeroed when no area is due so the root row yields zero
    logic [hpa_pkg::PSW-1:0]   r_s;
    logic [hpa_pkg::PSW-1:0]   r_x;
    logic [hpa_pkg::PSW-1:0]   r_y;
    logic [hpa_pkg::PSW-1:0]   r_z;
    logic [hpa_pkg::QW-1:0]    r_p1;
    logic [hpa_pkg::QW-1:0]    r_p2;
    logic [hpa_pkg::QW-1:0]    r_ll;
    logic [hpa_pkg::QW-1:0]    r_lh;
    logic [hpa_pkg::QW-1:0]    r_hl;
    logic [hpa_pkg::QW-1:0]    r_hh;
    logic [hpa_pkg::RW-1:0]    r_prod;

    // perimeter and degenerate flag ride alongside to the output
    logic [hpa_pkg::PERIM_W-1:0] r_pm [0:SBL-1];
    logic                        r_dg [0:SBL-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s  <= ok ? s : '0;
            r_x  <= ok ? fx[hpa_pkg::PSW-1:0] : '0;
            r_y  <= ok ? fy[hpa_pkg::PSW-1:0] : '0;
            r_z  <= ok ? fz[hpa_pkg::PSW-1:0] : '0;
            // s*x and y*z
            r_p1 <= hpa_pkg::QW'(r_s) * hpa_pkg::QW'(r_x);
            r_p2 <= hpa_pkg::QW'(r_y) * hpa_pkg::QW'(r_z);
            // split the wide product into four half-width partials
            r_ll <= hpa_pkg::QW'(r_p1[hpa_pkg::PSW-1:0]) * hpa_pkg::QW'(r_p2[hpa_pkg::PSW-1:0]);
            r_lh <= hpa_pkg::QW'(r_p1[hpa_pkg::PSW-1:0]) * hpa_pkg::QW'(r_p2[hpa_pkg::QW-1:hpa_pkg::PSW]);
            r_hl <= hpa_pkg::QW'(r_p1[hpa_pkg::QW-1:hpa_pkg::PSW]) * hpa_pkg::QW'(r_p2[hpa_pkg::PSW-1:0]);
            r_hh <= hpa_pkg::QW'(r_p1[hpa_pkg::QW-1:hpa_pkg::PSW]) * hpa_pkg::QW'(r_p2[hpa_pkg::QW-1:hpa_pkg::PSW]);
            r_prod <= {r_hh, r_ll}
                    + (hpa_pkg::RW'(hpa_pkg::RW'(r_lh) + hpa_pkg::RW'(r_hl)) << hpa_pkg::PSW);
            r_pm[0] <= n_pm;
            r_dg[0] <= !any_zero && any_neg;
            for (int j = 1; j < SBL; j++) begin
                r_pm[j] <= r_pm[j-1];
                r_dg[j] <= r_dg[j-1];
            end
        end
    end

    // area root row
    hpa_pkg::t_sq area_d [0:hpa_pkg::ASTEPS];

    assign area_d[0].rad  = r_prod;
    assign area_d[0].rem  = '0;
    assign area_d[0].root = '0;

    for (genvar k = 0; k < hpa_pkg::ASTEPS; k++) begin : g_acell
        hpa_sqrt_cell u_cell (
            .i_clk (i_clk), .i_en (en),
            .i_d   (area_d[k]), .o_d (area_d[k+1])
        );
    end

    // final result: drop the two low root bits, saturate to the area width
    logic [hpa_pkg::AXW-1:0] ax_wide;

    always_comb begin
        ax_wide        = hpa_pkg::AXW'(area_d[hpa_pkg::ASTEPS].root[hpa_pkg::QW-1:2]);
        fin.perimeter  = r_pm[SBL-1];
        fin.area       = (ax_wide > hpa_pkg::AXW'(hpa_pkg::AREA_MAX)) ? hpa_pkg::AREA_MAX
                                                                     : ax_wide[hpa_pkg::AREA_W-1:0];
        fin.degenerate = r_dg[SBL-1];
    end

    // output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (r_skv) begin
            if (!r_ov || take) begin
                r_ov  <= 1'b1;
                r_o   <= r_sk;
                r_skv <= 1'b0;
            end
        end else if (r_v[hpa_pkg::LAT-1]) begin
            if (!r_ov || take) begin
                r_ov <= 1'b1;
                r_o  <= fin;
            end else begin
                r_skv <= 1'b1;
                r_sk  <= fin;
            end
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.perimeter  = r_o.perimeter;
    assign o_res.area       = r_o.area;
    assign o_res.degenerate = r_o.degenerate;

    // a filled skid register always sits behind a waiting output transaction
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skv |-> r_ov)
        else $error("skid register full while output register empty");

    // a held last stage is not lost while the pipeline is stopped
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skv && r_v[hpa_pkg::LAT-1]) |=> r_v[hpa_pkg::LAT-1])
        else $error("last pipeline stage dropped during stall");

    // a degenerate triangle reports zero area
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.degenerate) |-> (o_res.area == '0))
        else $error("degenerate result with nonzero area");

    // an accepted transaction enters the first stage
    a_first_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && accept) |=> r_v[0])
        else $error("accepted transaction missing from first stage");

endmodule

>>> dv/tb_hpa_sb.sv
// Scoreboard class: predicts perimeter and Heron area per triangle and checks results.
`timescale 1ns / 100ps

class hpa_area_board;
    hpa_pkg::t_res pending[$];
    int            errors;

    function new();
        errors = 0;
    endfunction

    // exact floor square root of a nonnegative value up to 128 bits
    static function logic [63:0] isqrt(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= n) r = t;
        end
        return r;
    endfunction

    static function logic [63:0] side_len(longint x1, longint y1, longint x2, longint y2);
        longint dx;
        longint dy;
        logic [127:0] sq;
        dx = x1 - x2;
        dy = y1 - y2;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        return isqrt(sq);
    endfunction

    // note one accepted triangle
    function void note_triangle(logic signed [23:0] ax, ay, bx, by, cx, cy);
        longint a, b, c, s, x, y, z;
        logic [127:0] prod;
        hpa_pkg::t_res r;
        a = longint'(side_len(ax, ay, bx, by));
        b = longint'(side_len(bx, by, cx, cy));
        c = longint'(side_len(cx, cy, ax, ay));
        s = a + b + c;
        x = b + c - a;
        y = a + c - b;
        z = a + b - c;
        r.perimeter  = (s > 64'h7FFFFFF) ? hpa_pkg::PERIM_MAX : s[26:0];
        r.area       = '0;
        r.degenerate = 1'b0;
        if (s == 0 || x == 0 || y == 0 || z == 0) begin
            r.area = '0;
        end else if (x < 0 || y < 0 || z < 0) begin
            r.degenerate = 1'b1;
        end else begin
            prod = (128'(s) * 128'(x)) * (128'(y) * 128'(z));
            r.area = 48'(isqrt(prod) >> 2);
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [26:0] perim, logic [47:0] area, logic degen);
        hpa_pkg::t_res e;
        if (pending.size() == 0) begin
            $error("result with nothing pending: perimeter %0d area %0d", perim, area);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (perim !== e.perimeter) begin
            $error("perimeter: expected %0d actual %0d", e.perimeter, perim);
            errors++;
        end
        if (area !== e.area) begin
            $error("area: expected %0d actual %0d", e.area, area);
            errors++;
        end
        if (degen !== e.degenerate) begin
            $error("degenerate: expected %0d actual %0d", e.degenerate, degen);
            errors++;
        end
    endfunction
endclass

>>> dv/tb_top.sv
// Testbench top: drives triangles, stalls results at random, checks against the predictor.
`timescale 1ns / 100ps

module tb_top;
    localparam int N_RANDOM  = 630;
    localparam int LATENCY   = hpa_pkg::LAT + 1;
    localparam int IDLE_CAP  = 5000;

    logic i_clk;
    logic i_rst_n;
    int   idle_pct;
    int   stall_pct;
    int   quiet_cycles;
    bit   stim_done;
    bit   timed_out;
    hpa_area_board board;

    hpa_tri_if tri_ch();
    hpa_res_if res_ch();

    triangle_perimeter_area u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch.sink),
        .o_res   (res_ch.source)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // drive one triangle and hold it until the transaction completes
    task automatic send_triangle(logic signed [23:0] ax, ay, bx, by, cx, cy);
        while (($urandom_range(99) < idle_pct)) begin
            tri_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tri_ch.valid <= 1'b1;
        tri_ch.ax <= ax; tri_ch.ay <= ay;
        tri_ch.bx <= bx; tri_ch.by <= by;
        tri_ch.cx <= cx; tri_ch.cy <= cy;
        do @(posedge i_clk); while (!tri_ch.ready);
        board.note_triangle(ax, ay, bx, by, cx, cy);
    endtask

    // pick a coordinate: mostly small, sometimes full-range or an extreme
    function automatic logic signed [23:0] pick_coord(int span);
        case ($urandom_range(9))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2, 3: return 24'($urandom);
            default: return 24'(int'($urandom_range(2 * span)) - span);
        endcase
    endfunction

    // result side: random backpressure, check each transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                board.check_result(res_ch.perimeter, res_ch.area, res_ch.degenerate);
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: count cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_CAP && !timed_out) begin
            timed_out = 1'b1;
            $display("triangle_perimeter_area test failed");
            $finish;
        end
    end

    initial begin
        int span;
        logic signed [23:0] px, py;
        board        = new();
        quiet_cycles = 0;
        timed_out    = 1'b0;
        stim_done    = 1'b0;
        idle_pct     = 35;
        stall_pct    = 35;
        i_rst_n      = 1'b0;
        tri_ch.valid = 1'b0;
        {tri_ch.ax, tri_ch.ay, tri_ch.bx, tri_ch.by, tri_ch.cx, tri_ch.cy} = '0;
        res_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: point, collinear, right triangle, extremes, near-degenerate
        send_triangle(0, 0, 0, 0, 0, 0);
        send_triangle(-24'sh800000, -24'sh800000, -24'sh800000, -24'sh800000,
                      -24'sh800000, -24'sh800000);
        send_triangle(0, 0, 256, 0, 512, 0);
        send_triangle(0, 0, 768, 0, 0, 1024);
        send_triangle(-24'sh800000, -24'sh800000, 24'sh7FFFFF, -24'sh800000,
                      24'sh7FFFFF, 24'sh7FFFFF);
        send_triangle(-24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000,
                      -24'sh800000, -24'sh800000);
        send_triangle(24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000, 0, 1);
        send_triangle(0, 0, 1, 1, 2, 3);
        send_triangle(0, 0, 3, 1, 6, 2);
        send_triangle(0, 0, 1, 0, 0, 1);
        send_triangle(-24'sh800000, 0, 24'sh7FFFFF, 0, 0, 24'sh7FFFFF);
        send_triangle(1, -1, -1, 1, 24'sh555555, -24'sh2AAAAA);
        send_triangle(0, 0, 1000, 1, 2000, 3);
        send_triangle(5, 5, 5, 5, 100, -100);
        send_triangle(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                      24'sh7FFFFF, 24'sh7FFFFF);

        // random: a stretch with no idling, then idling on both sides
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i < 100) begin
                idle_pct = 0; stall_pct = 0;
            end else begin
                idle_pct = 35; stall_pct = 35;
            end
            span = ($urandom_range(3) == 0) ? 8388607 : (1 << $urandom_range(2, 16));
            if ($urandom_range(5) == 0) begin
                // nearly collinear: flooring can break the triangle inequality
                px = 24'(int'($urandom_range(2000)) - 1000);
                py = 24'(int'($urandom_range(2000)) - 1000);
                send_triangle(0, 0, px, py, 24'(2 * px + int'($urandom_range(2)) - 1),
                              24'(2 * py + int'($urandom_range(2)) - 1));
            end else begin
                send_triangle(pick_coord(span), pick_coord(span), pick_coord(span),
                              pick_coord(span), pick_coord(span), pick_coord(span));
            end
        end
        tri_ch.valid <= 1'b0;
        stim_done = 1'b1;

        // drain, then allow the pipeline latency
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("triangle_perimeter_area test passed");
        else
            $display("triangle_perimeter_area test failed");
        $finish;
    end
endmodule

>>> filelist.f
hdl/hpa_pkg.sv
hdl/hpa_if.sv
hdl/hpa_sqrt_cell.sv
hdl/hpa_side.sv
hdl/triangle_perimeter_area.sv
dv/tb_hpa_sb.sv
dv/tb_top.sv
